@@ rtl/core/bspa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier slot pool allocator package
// Shared widths, codes, item types and the slot memory word layout.
// ----------------------------------------------------------------------------
package bspa_pkg;

  // Default geometry of the slot pool.
  localparam int unsigned NUM_POOLS_DEF  = 4;
  localparam int unsigned POOL_DEPTH_DEF = 8;

  // Field widths.
  localparam int unsigned POOLS_W    = 3;
  localparam int unsigned SLOTS_W    = 4;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CTX_W      = 32;
  localparam int unsigned ROOT_W     = 16;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned FPOOL_W    = 2;
  localparam int unsigned FSLOT_W    = 3;

  // Reset values of the configuration registers.
  localparam logic [POOLS_W-1:0] POOLS_RST = 3'd4;
  localparam logic [SLOTS_W-1:0] SLOTS_RST = 4'd8;

  typedef enum logic [0:0] {
    FUNC_ATTACH = 1'b0,
    FUNC_FREE   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_RES    = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_POOLS_IN_USE   = 1'b0,
    REG_SLOTS_PER_POOL = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_MATCH,
    FSM_ALLOC,
    FSM_FREE_RD,
    FSM_FREE_WR,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    func_e              func;
    logic               first_instance;
    logic [CTX_W-1:0]   context_id;
    logic [ROOT_W-1:0]  root_id;
    logic [CNT_W-1:0]   group_size;
    logic [FPOOL_W-1:0] free_pool;
    logic [FSLOT_W-1:0] free_slot;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               got_resource;
    logic [FPOOL_W-1:0] pool_index;
    logic [FSLOT_W-1:0] slot_index;
    logic               released;
  } res_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [CTX_W-1:0]  ctx;
    logic [ROOT_W-1:0] root;
    logic [CNT_W-1:0]  attach;
    logic [CNT_W-1:0]  freed;
    logic [CNT_W-1:0]  member;
  } slot_word_t;

endpackage

@@ rtl/core/bspa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier slot pool allocator channels
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface bspa_item_if;
  import bspa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bspa_res_if;
  import bspa_pkg::*;
  logic valid;
  logic ready;
  res_t res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

interface bspa_cfg_if;
  import bspa_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_e              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bspa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bspa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/barrier_slot_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrier slot pool allocator
// Attaches groups to barrier slots by key, claims free slots round-robin over
// the sub-pools, and releases a slot once all its members have freed it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------
//  cfg_i   | in  | valid / ready       | index (register), data
//  in_i    | in  | valid / ready       | item: func, key, size, free slot
//  out_o   | out | valid / ready       | res: status, slot, released
//
// The key search covers the U usable slots (32 at reset values) and stops
// at the first match; a miss goes on to the claim search for a first
// instance, which ends on a free slot or after all U usable slots. The key
// search reads the slot memory one
// entry per cycle and the claim search walks the busy bits one slot per
// cycle. The busy bits are flip-flops cleared by reset, so no clearing pass
// runs. A new item is taken in the cycle after the previous result is loaded
// into the output register; a stalled output holds the block in its final
// state.
module barrier_slot_pool_allocator #(
  parameter int unsigned NUM_POOLS  = bspa_pkg::NUM_POOLS_DEF,
  parameter int unsigned POOL_DEPTH = bspa_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bspa_cfg_if.sink    cfg_i,
  bspa_item_if.sink   in_i,
  bspa_res_if.source  out_o
);

  import bspa_pkg::*;

  localparam int unsigned NSLOTS = NUM_POOLS * POOL_DEPTH;
  localparam int unsigned AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int unsigned PI_W   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned PC_W   = $clog2(NUM_POOLS + 1);
  localparam int unsigned SC_W   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned PCMP_W = (PC_W > POOLS_W) ? PC_W : POOLS_W;
  localparam int unsigned SCMP_W = (SC_W > SLOTS_W) ? SC_W : SLOTS_W;
  localparam int unsigned WORD_W = $bits(slot_word_t);

  // Flat slot number of a (sub-pool, slot) pair.
  function automatic logic [AW-1:0] slot_addr(input int unsigned pool,
                                              input int unsigned slot);
    int unsigned flat;
    flat = pool * POOL_DEPTH + slot;
    return AW'(flat);
  endfunction

  fsm_e                state_q, state_d;
  in_item_t            item_q;
  logic [POOLS_W-1:0]  pools_q;
  logic [SLOTS_W-1:0]  slots_q;
  logic [NSLOTS-1:0]   busy_q;
  logic [PI_W-1:0]     last_q;

  // Search counters: key search uses pool_q, claim search uses rr_q/cnt_q.
  logic [PC_W-1:0]     pool_q;
  logic [SC_W-1:0]     slot_q;
  logic [PI_W-1:0]     rr_q;
  logic [PC_W-1:0]     cnt_q;

  // Entry whose read data arrives in this cycle during the key search.
  logic                pend_v_q;
  logic [AW-1:0]       pend_k_q;
  logic [PC_W-1:0]     pend_p_q;
  logic [SC_W-1:0]     pend_s_q;

  res_t                res_q, res_d;
  logic                out_valid_q;
  res_t                out_q;

  logic [PC_W-1:0]     np_eff;
  logic [SC_W-1:0]     ns_eff;
  logic                in_fire;
  logic                issue;
  logic                slot_wrap;
  logic [AW-1:0]       scan_k;
  logic                hit;
  logic [PI_W-1:0]     rr_start;
  logic [PI_W-1:0]     rr_next;
  logic [AW-1:0]       alloc_k;
  logic                alloc_live;
  logic                claim;
  logic [AW-1:0]       free_k;
  logic                free_ok;
  logic [CNT_W-1:0]    free_cnt_nxt;
  logic                slot_drop;
  logic                out_load;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  slot_word_t          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  slot_word_t          ram_rdata;
  logic [WORD_W-1:0]   ram_rdata_raw;

  bspa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NSLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = slot_word_t'(ram_rdata_raw);

  // Handshakes.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == FSM_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.res   = out_q;
  assign out_load    = (state_q == FSM_DONE) && (!out_valid_q || out_o.ready);

  // Registers above the built geometry act as the geometry itself.
  assign np_eff = (PCMP_W'(pools_q) > PCMP_W'(NUM_POOLS)) ? PC_W'(NUM_POOLS)
                                                          : PC_W'(pools_q);
  assign ns_eff = (SCMP_W'(slots_q) > SCMP_W'(POOL_DEPTH)) ? SC_W'(POOL_DEPTH)
                                                           : SC_W'(slots_q);

  // Search bookkeeping; the slot wrap is shared by both walks.
  assign slot_wrap = (slot_q + SC_W'(1)) == ns_eff;
  assign issue     = (pool_q < np_eff) && (ns_eff != '0);
  assign scan_k    = slot_addr(32'(pool_q), 32'(slot_q));

  // Key compare on the entry read in the previous cycle.
  assign hit = (state_q == FSM_MATCH) && pend_v_q && busy_q[pend_k_q] &&
               (ram_rdata.ctx == item_q.context_id) &&
               (ram_rdata.root == item_q.root_id);

  // Round-robin claim search over the busy bits.
  assign rr_start   = ((PC_W'(last_q) + PC_W'(1)) >= np_eff) ? '0
                                                             : last_q + PI_W'(1);
  assign rr_next    = ((PC_W'(rr_q) + PC_W'(1)) >= np_eff) ? '0 : rr_q + PI_W'(1);
  assign alloc_k    = slot_addr(32'(rr_q), 32'(slot_q));
  assign alloc_live = (cnt_q < np_eff) && (ns_eff != '0);
  assign claim      = (state_q == FSM_ALLOC) && alloc_live && !busy_q[alloc_k];

  // Free request checks and count update.
  assign free_k  = slot_addr(32'(item_q.free_pool), 32'(item_q.free_slot));
  assign free_ok = (PCMP_W'(item_q.free_pool) < PCMP_W'(np_eff)) &&
                   (SCMP_W'(item_q.free_slot) < SCMP_W'(ns_eff)) &&
                   busy_q[free_k];
  assign free_cnt_nxt = ram_rdata.freed + CNT_W'(1);
  assign slot_drop    = (free_cnt_nxt == ram_rdata.member);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.item.func == FUNC_FREE) ? FSM_FREE_RD : FSM_MATCH;
        end
      end
      FSM_MATCH: begin
        if (hit) begin
          state_d = FSM_DONE;
        end else if (!issue && !pend_v_q) begin
          state_d = item_q.first_instance ? FSM_ALLOC : FSM_DONE;
        end
      end
      FSM_ALLOC: begin
        if (claim || !alloc_live) begin
          state_d = FSM_DONE;
        end
      end
      FSM_FREE_RD: begin
        state_d = free_ok ? FSM_FREE_WR : FSM_DONE;
      end
      FSM_FREE_WR: begin
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_load) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Memory accesses and result for the current state.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = scan_k;
    ram_we    = 1'b0;
    ram_waddr = pend_k_q;
    ram_wdata = ram_rdata;
    res_d     = res_q;
    case (state_q)
      FSM_IDLE: begin
        res_d = '{status: STATUS_NOT_FOUND, got_resource: 1'b0,
                  pool_index: '0, slot_index: '0, released: 1'b0};
      end
      FSM_MATCH: begin
        ram_re = issue;
        if (hit) begin
          // Known key: one more attach, member count follows the request.
          ram_we              = 1'b1;
          ram_wdata.attach    = ram_rdata.attach + CNT_W'(1);
          ram_wdata.member    = item_q.group_size;
          res_d.status        = STATUS_OK;
          res_d.got_resource  = 1'b1;
          res_d.pool_index    = FPOOL_W'(pend_p_q);
          res_d.slot_index    = FSLOT_W'(pend_s_q);
        end
      end
      FSM_ALLOC: begin
        ram_waddr    = alloc_k;
        ram_wdata    = '{ctx: item_q.context_id, root: item_q.root_id,
                         attach: CNT_W'(1), freed: '0, member: item_q.group_size};
        res_d.status = STATUS_NO_RES;
        if (claim) begin
          ram_we             = 1'b1;
          res_d.status       = STATUS_OK;
          res_d.got_resource = 1'b1;
          res_d.pool_index   = FPOOL_W'(rr_q);
          res_d.slot_index   = FSLOT_W'(slot_q);
        end
      end
      FSM_FREE_RD: begin
        ram_raddr = free_k;
        ram_re    = free_ok;
      end
      FSM_FREE_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = free_k;
        ram_wdata.freed = free_cnt_nxt;
        res_d.status    = STATUS_OK;
        res_d.released  = slot_drop;
      end
      FSM_DONE: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pools_q     <= POOLS_RST;
      slots_q     <= SLOTS_RST;
      busy_q      <= '0;
      last_q      <= PI_W'(NUM_POOLS - 1);
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_POOLS_IN_USE:   pools_q <= cfg_i.data[POOLS_W-1:0];
          REG_SLOTS_PER_POOL: slots_q <= cfg_i.data[SLOTS_W-1:0];
          default: ;
        endcase
      end

      if (claim) begin
        busy_q[alloc_k] <= 1'b1;
        last_q          <= rr_q;
      end
      if ((state_q == FSM_FREE_WR) && slot_drop) begin
        busy_q[free_k] <= 1'b0;
      end

      pend_v_q <= (state_q == FSM_MATCH) && issue && !hit;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, counters and result payload.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    if (in_fire) begin
      item_q <= in_i.item;
      pool_q <= '0;
      slot_q <= '0;
    end
    if (state_q == FSM_MATCH) begin
      pend_k_q <= scan_k;
      pend_p_q <= pool_q;
      pend_s_q <= slot_q;
      if (issue) begin
        if (slot_wrap) begin
          slot_q <= '0;
          pool_q <= pool_q + PC_W'(1);
        end else begin
          slot_q <= slot_q + SC_W'(1);
        end
      end
      if (state_d == FSM_ALLOC) begin
        rr_q   <= rr_start;
        cnt_q  <= '0;
        slot_q <= '0;
      end
    end
    if ((state_q == FSM_ALLOC) && alloc_live && !claim) begin
      if (slot_wrap) begin
        slot_q <= '0;
        cnt_q  <= cnt_q + PC_W'(1);
        rr_q   <= rr_next;
      end else begin
        slot_q <= slot_q + SC_W'(1);
      end
    end
  end

  // A result reaches the output register only from the final state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == FSM_DONE))
    else $error("result presented without passing the final state");

  // A claimed slot is marked busy in the following cycle.
  a_claim_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim |=> busy_q[$past(alloc_k)])
    else $error("claimed slot not marked busy");

  // A released slot is free in the following cycle.
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == FSM_FREE_WR) && slot_drop) |=> !busy_q[$past(free_k)])
    else $error("released slot still busy");

  // An obtained slot always reports success and never a release.
  a_got_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.got_resource) |->
      ((out_q.status == STATUS_OK) && !out_q.released))
    else $error("slot obtained with a failing status");

  // An accepted item starts either the key search or the free read.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == FSM_MATCH) || (state_q == FSM_FREE_RD)))
    else $error("accepted item did not start processing");

endmodule
